>>> sv/fdc16_pkg.sv
// fdc16_pkg: shared types, constants and the byte-wide CRC-16/MODBUS step
// for the frame decoder. No dependencies.
package fdc16_pkg;

  localparam int MAX_PAYLOAD_DEF = 256;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;   // reflected 0x8005

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION      = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_BAD_CMD = 2'd2,
    ST_BAD_CRC = 2'd3
  } status_t;

  typedef struct packed {
    logic        kind;          // 0 payload byte, 1 end-of-frame status
    logic [7:0]  payload_byte;
    status_t     status;
    logic [7:0]  command;
    logic [7:0]  sequence_res;
    logic [8:0]  payload_length;
  } result_t;

  // one byte through the LSB-first CRC, eight shift steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> sv/frame_decoder_crc16.sv
// frame_decoder_crc16: byte-serial deframer with CRC-16/MODBUS check.
// Depends on fdc16_pkg (types, register indexes, CRC byte step).
//
// The block takes one frame byte per item on the in_ stream (in_tlast marks
// the last byte) and returns payload bytes as they arrive plus one status
// item at end of frame. Frame: start byte 1, start byte 2, version, command,
// sequence, 16-bit LE length, payload, 16-bit LE CRC over bytes 2..6 and the
// payload. Payload items are sent before the frame is checked; discard them
// unless the closing status is OK. One item is accepted every clock cycle
// while in_tready is high; each result is registered before it appears on
// out_. The combinational byte-wide CRC update sits between the frame state
// registers and the output register. A two-entry output stage (output
// register plus skid register) lets the input keep accepting while out_tready
// is low, until a result is parked in the skid register. Configuration writes
// must happen only while no frame is in progress.
module frame_decoder_crc16
  import fdc16_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF   // 1 .. 511
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,    // [7:0] data_byte
  input  logic                  in_tlast,    // end_of_frame
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata,   // [7:0] payload_byte, [9:8] status,
                                             // [17:10] command, [25:18] sequence_res,
                                             // [34:26] payload_length, [39:35] zero
  output logic                  out_tuser    // kind
);

  // byte counter saturates at the larger of 511 and MAX_PAYLOAD + 10
  localparam int POS_LIMIT = (MAX_PAYLOAD + 10 > 511) ? MAX_PAYLOAD + 10 : 511;
  localparam int POS_W = $clog2(POS_LIMIT + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(POS_LIMIT);
  localparam logic [16:0] MAX_LEN17 = 17'(MAX_PAYLOAD);

  // ---------------- configuration registers ----------------
  logic [7:0] start1_r, start2_r, version_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start1_r  <= '0;
      start2_r  <= '0;
      version_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_FIRST:  start1_r  <= cfg_wdata;
        CFG_START_SECOND: start2_r  <= cfg_wdata;
        CFG_VERSION:      version_r <= cfg_wdata;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------- frame state ----------------
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic             hdr_ok_r, hdr_ok_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [7:0]       seq_r, seq_nxt;
  logic [15:0]      chk_r, chk_nxt;

  logic             in_fire;
  logic [15:0]      crc_step;
  logic [16:0]      pos17, off17, len17;
  logic             is_payload;
  logic [POS_W-1:0] count;
  result_t          res;
  logic             res_valid;

  assign in_fire  = in_tvalid && in_tready;
  assign crc_step = crc16_byte(crc_r, in_tdata);
  assign pos17    = 17'(pos_r);
  assign off17    = pos17 - 17'd7;          // payload offset, valid from position 7
  assign len17    = {1'b0, len_r};
  assign count    = (pos_r < POS_MAX) ? pos_r + 1'b1 : POS_MAX;

  always_comb begin
    logic [16:0] len_end;
    len_nxt    = len_r;
    crc_nxt    = crc_r;
    hdr_ok_nxt = hdr_ok_r;
    cmd_nxt    = cmd_r;
    seq_nxt    = seq_r;
    chk_nxt    = chk_r;
    is_payload = 1'b0;

    // absorb the byte at its frame position
    priority if (pos_r == POS_W'(0)) begin
      if (in_tdata != start1_r) hdr_ok_nxt = 1'b0;
    end else if (pos_r == POS_W'(1)) begin
      if (in_tdata != start2_r) hdr_ok_nxt = 1'b0;
    end else if (pos_r <= POS_W'(6)) begin
      if (pos_r == POS_W'(2) && in_tdata != version_r) hdr_ok_nxt = 1'b0;
      if (pos_r == POS_W'(3)) cmd_nxt = in_tdata;
      if (pos_r == POS_W'(4)) seq_nxt = in_tdata;
      if (pos_r == POS_W'(5)) len_nxt = {len_r[15:8], in_tdata};
      if (pos_r == POS_W'(6)) len_nxt = {in_tdata, len_r[7:0]};
      crc_nxt = crc_step;
    end else if (off17 < len17) begin
      crc_nxt    = crc_step;
      is_payload = 1'b1;
    end else if (off17 == len17) begin
      chk_nxt = {chk_r[15:8], in_tdata};
    end else if (off17 == len17 + 17'd1) begin
      chk_nxt = {in_tdata, chk_r[7:0]};
    end else begin
      // bytes past the check are only counted
    end

    pos_nxt = count;

    // result for this byte
    res       = '0;
    res_valid = 1'b0;
    len_end   = {1'b0, len_nxt} + 17'd9;
    if (in_tlast) begin
      res_valid = 1'b1;
      res.kind  = 1'b1;
      priority if (count < POS_W'(9)) begin
        res.status = ST_BAD_LEN;
      end else if (!hdr_ok_nxt) begin
        res.status = ST_BAD_CMD;
      end else if ({1'b0, len_nxt} > MAX_LEN17) begin
        res.status = ST_BAD_LEN;
      end else if (17'(count) != len_end) begin
        res.status = ST_BAD_LEN;
      end else if (chk_nxt != crc_nxt) begin
        res.status = ST_BAD_CRC;
      end else begin
        res.status         = ST_OK;
        res.command        = cmd_nxt;
        res.sequence_res   = seq_nxt;
        res.payload_length = len_nxt[8:0];
      end
      // end of frame: back to the idle frame state
      pos_nxt    = '0;
      len_nxt    = '0;
      crc_nxt    = CRC_INIT;
      hdr_ok_nxt = 1'b1;
      cmd_nxt    = '0;
      seq_nxt    = '0;
      chk_nxt    = '0;
    end else if (is_payload) begin
      res_valid        = 1'b1;
      res.payload_byte = in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      len_r    <= '0;
      crc_r    <= CRC_INIT;
      hdr_ok_r <= 1'b1;
      cmd_r    <= '0;
      seq_r    <= '0;
      chk_r    <= '0;
    end else if (in_fire) begin
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      crc_r    <= crc_nxt;
      hdr_ok_r <= hdr_ok_nxt;
      cmd_r    <= cmd_nxt;
      seq_r    <= seq_nxt;
      chk_r    <= chk_nxt;
    end
  end

  // ---------------- output register + skid ----------------
  result_t out_r, skid_r;
  logic    out_valid_r, skid_valid_r;
  logic    new_valid, out_free;

  assign in_tready = !skid_valid_r;
  assign new_valid = in_fire && res_valid;
  assign out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      // output slot opens: drain skid first, else take the new item
      out_valid_r  <= skid_valid_r || new_valid;
      skid_valid_r <= 1'b0;
    end else if (new_valid) begin
      skid_valid_r <= 1'b1;  // output stalled: park the new item
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (new_valid) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {5'b0, out_r.payload_length, out_r.sequence_res, out_r.command,
                       out_r.status, out_r.payload_byte};

  // ---------------- assertions ----------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item while output register is empty");

  a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> pos_r == '0 && crc_r == CRC_INIT && hdr_ok_r)
    else $error("frame state not cleared after end of frame");

  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_MAX)
    else $error("byte counter beyond saturation limit");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[39:8] == '0)
    else $error("payload item carries status fields");

  a_bad_no_info: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && out_tdata[9:8] != ST_OK |-> out_tdata[34:10] == '0)
    else $error("failed frame reports header fields");

endmodule
